FILE: src/keyed_table_insert_lookup_update_defines.svh
// ----------------------------------------------------------------------------
// keyed table assertion macros
// property wrappers for the checker module
// ----------------------------------------------------------------------------
`ifndef KEYED_TABLE_INSERT_LOOKUP_UPDATE_DEFINES_SVH
`define KEYED_TABLE_INSERT_LOOKUP_UPDATE_DEFINES_SVH

// property checked only outside reset
`define KTAB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define KTAB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ktab_pkg.sv
// ----------------------------------------------------------------------------
// ktab_pkg
// types, codes and constants shared by the keyed table modules
// ----------------------------------------------------------------------------
package ktab_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   localparam int OPCODE_W = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 7;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_UPDATE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SCAN,
      S_QREAD,
      S_QUSE,
      S_DONE
   } state_type;

   // which result the datapath builds
   typedef enum logic [2:0] {
      RES_FULL,
      RES_DUP,
      RES_MISS,
      RES_INSERT,
      RES_FOUND,
      RES_UPDATE
   } res_type;

   typedef struct packed {
      logic    accept;
      logic    scan_en;
      logic    res_load;
      res_type res_sel;
      logic    out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic                full;
      logic                hit;
      logic                exhausted;
      logic                out_free;
   } dp_status_type;

endpackage

FILE: src/ktab_if.sv
// ----------------------------------------------------------------------------
// ktab_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface ktab_req_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ktab_pkg::OPCODE_W-1:0]  opcode;
   logic signed [ktab_pkg::DATA_W-1:0]    part_key;
   logic signed [ktab_pkg::DATA_W-1:0]    amount;

   modport source (output valid, output opcode, output part_key, output amount,
                   input ready);
   modport sink (input valid, input opcode, input part_key, input amount,
                 output ready);
endinterface

interface ktab_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic        [ktab_pkg::STATUS_W-1:0]  status;
   logic signed [ktab_pkg::DATA_W-1:0]    quantity;
   logic        [ktab_pkg::SLOT_W-1:0]    slot;

   modport source (output valid, output status, output quantity, output slot,
                   input ready);
   modport sink (input valid, input status, input quantity, input slot,
                 output ready);
endinterface

FILE: src/ktab_ram.sv
// ----------------------------------------------------------------------------
// ktab_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ktab_ram #(
   parameter int WIDTH = ktab_pkg::DATA_W,
   parameter int DEPTH = ktab_pkg::CAPACITY_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ktab_ctrl.sv
// ----------------------------------------------------------------------------
// ktab_ctrl
// sequencer: accept, scan, quantity access and result hand-off
// ----------------------------------------------------------------------------
module ktab_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ktab_pkg::dp_status_type status,
   output ktab_pkg::ctrl_cmd_type  cmd
);

   ktab_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ktab_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ktab_pkg::S_IDLE: begin
            if (req_valid) state_in = ktab_pkg::S_CHECK;
         end
         ktab_pkg::S_CHECK: begin
            if (status.opcode == ktab_pkg::OP_INSERT && status.full) begin
               state_in = ktab_pkg::S_DONE;
            end else if (status.opcode == ktab_pkg::OP_INSERT ||
                         status.opcode == ktab_pkg::OP_SEARCH ||
                         status.opcode == ktab_pkg::OP_UPDATE) begin
               state_in = ktab_pkg::S_SCAN;
            end else begin
               state_in = ktab_pkg::S_DONE;
            end
         end
         ktab_pkg::S_SCAN: begin
            if (status.hit) begin
               state_in = (status.opcode == ktab_pkg::OP_INSERT) ? ktab_pkg::S_DONE
                                                                 : ktab_pkg::S_QREAD;
            end else if (status.exhausted) begin
               state_in = ktab_pkg::S_DONE;
            end
         end
         ktab_pkg::S_QREAD: state_in = ktab_pkg::S_QUSE;
         ktab_pkg::S_QUSE:  state_in = ktab_pkg::S_DONE;
         ktab_pkg::S_DONE: begin
            if (status.out_free) state_in = ktab_pkg::S_IDLE;
         end
         default: state_in = ktab_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.res_sel  = ktab_pkg::RES_MISS;
      unique case (state_ff)
         ktab_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ktab_pkg::S_CHECK: begin
            if (status.opcode == ktab_pkg::OP_INSERT && status.full) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = ktab_pkg::RES_FULL;
            end else if (!(status.opcode == ktab_pkg::OP_INSERT ||
                           status.opcode == ktab_pkg::OP_SEARCH ||
                           status.opcode == ktab_pkg::OP_UPDATE)) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = ktab_pkg::RES_MISS;
            end
         end
         ktab_pkg::S_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.hit) begin
               if (status.opcode == ktab_pkg::OP_INSERT) begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = ktab_pkg::RES_DUP;
               end
            end else if (status.exhausted) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = (status.opcode == ktab_pkg::OP_INSERT) ? ktab_pkg::RES_INSERT
                                                                     : ktab_pkg::RES_MISS;
            end
         end
         ktab_pkg::S_QREAD: begin
            cmd.res_load = 1'b0;
         end
         ktab_pkg::S_QUSE: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = (status.opcode == ktab_pkg::OP_UPDATE) ? ktab_pkg::RES_UPDATE
                                                                  : ktab_pkg::RES_FOUND;
         end
         ktab_pkg::S_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: src/ktab_dp.sv
// ----------------------------------------------------------------------------
// ktab_dp
// datapath: command latch, key scan pipeline, stores, fill count, result regs
// ----------------------------------------------------------------------------
module ktab_dp #(
   parameter int CAPACITY = ktab_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ktab_pkg::ctrl_cmd_type                cmd,
   output ktab_pkg::dp_status_type               status,
   input  logic        [ktab_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic signed [ktab_pkg::DATA_W-1:0]    req_part_key,
   input  logic signed [ktab_pkg::DATA_W-1:0]    req_amount,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [ktab_pkg::STATUS_W-1:0]  rsp_status,
   output logic signed [ktab_pkg::DATA_W-1:0]    rsp_quantity,
   output logic        [ktab_pkg::SLOT_W-1:0]    rsp_slot
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   // latched command word
   logic        [ktab_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic signed [ktab_pkg::DATA_W-1:0]   key_ff, key_in;
   logic signed [ktab_pkg::DATA_W-1:0]   amt_ff, amt_in;

   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0] slot_ff, slot_in;

   logic        [ktab_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic signed [ktab_pkg::DATA_W-1:0]   res_qty_ff, res_qty_in;
   logic        [IDX_W-1:0]              res_slot_ff, res_slot_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic        [ktab_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic signed [ktab_pkg::DATA_W-1:0]   rsp_qty_ff, rsp_qty_in;
   logic        [ktab_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                       key_we;
   logic                       qty_we;
   logic [IDX_W-1:0]           qty_waddr;
   logic [ktab_pkg::DATA_W-1:0] qty_wdata;
   logic [ktab_pkg::DATA_W-1:0] key_rdata;
   logic [ktab_pkg::DATA_W-1:0] qty_rdata;
   logic signed [ktab_pkg::DATA_W-1:0] qty_sum;
   logic                       hit;

   ktab_ram #(.WIDTH(ktab_pkg::DATA_W), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (key_rdata)
   );

   ktab_ram #(.WIDTH(ktab_pkg::DATA_W), .DEPTH(CAPACITY)) u_qty_ram (
      .clock   (clock),
      .wr_en   (qty_we),
      .wr_addr (qty_waddr),
      .wr_data (qty_wdata),
      .rd_addr (slot_ff),
      .rd_data (qty_rdata)
   );

   // the registered key ram output is compared against the latched key
   assign hit     = cmp_v_ff && (key_rdata == key_ff);
   assign qty_sum = $signed(qty_rdata) + amt_ff;

   assign status.opcode    = op_ff;
   assign status.full      = (fill_ff == FULL_COUNT);
   assign status.hit       = hit;
   assign status.exhausted = !cmp_v_ff && (idx_ff == fill_ff);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      amt_in        = amt_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      cmp_v_in      = cmp_v_ff;
      cmp_idx_in    = cmp_idx_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_qty_in    = res_qty_ff;
      res_slot_in   = res_slot_ff;
      key_we        = 1'b0;
      qty_we        = 1'b0;
      qty_waddr     = slot_ff;
      qty_wdata     = qty_sum;

      if (cmd.accept) begin
         op_in    = req_opcode;
         key_in   = req_part_key;
         amt_in   = req_amount;
         idx_in   = '0;
         cmp_v_in = 1'b0;
      end

      if (cmd.scan_en) begin
         if (idx_ff < fill_ff) begin
            idx_in     = idx_ff + CNT_W'(1);
            cmp_v_in   = 1'b1;
            cmp_idx_in = idx_ff[IDX_W-1:0];
         end else begin
            cmp_v_in = 1'b0;
         end
         if (hit) slot_in = cmp_idx_ff;
      end

      if (cmd.res_load) begin
         case (cmd.res_sel)
            ktab_pkg::RES_FULL: begin
               res_status_in = ktab_pkg::ST_FULL;
               res_qty_in    = '0;
               res_slot_in   = '0;
            end
            ktab_pkg::RES_DUP: begin
               res_status_in = ktab_pkg::ST_DUP;
               res_qty_in    = '0;
               res_slot_in   = '0;
            end
            ktab_pkg::RES_INSERT: begin
               res_status_in = ktab_pkg::ST_OK;
               res_qty_in    = amt_ff;
               res_slot_in   = fill_ff[IDX_W-1:0];
               key_we        = 1'b1;
               qty_we        = 1'b1;
               qty_waddr     = fill_ff[IDX_W-1:0];
               qty_wdata     = amt_ff;
               fill_in       = fill_ff + CNT_W'(1);
            end
            ktab_pkg::RES_FOUND: begin
               res_status_in = ktab_pkg::ST_OK;
               res_qty_in    = qty_rdata;
               res_slot_in   = slot_ff;
            end
            ktab_pkg::RES_UPDATE: begin
               res_status_in = ktab_pkg::ST_OK;
               res_qty_in    = qty_sum;
               res_slot_in   = slot_ff;
               qty_we        = 1'b1;
            end
            default: begin
               res_status_in = ktab_pkg::ST_MISSING;
               res_qty_in    = '0;
               res_slot_in   = '0;
            end
         endcase
      end
   end

   // output register, holds the word until taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_qty_in    = rsp_qty_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_qty_in    = res_qty_ff;
         rsp_slot_in   = ktab_pkg::SLOT_W'(res_slot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cmp_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         cmp_v_ff     <= cmp_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      amt_ff        <= amt_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_qty_ff    <= res_qty_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_qty_ff    <= rsp_qty_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_quantity = rsp_qty_ff;
   assign rsp_slot     = rsp_slot_ff;

endmodule

FILE: src/keyed_table_insert_lookup_update.sv
// operation: the key scan walks the stored entries in order, and a hit ends it
//   early; one command in flight at a time, no new command is taken before the
//   last result is loaded into the output register; the command rate is set by
//   the key scan through the single read port of the key ram
// reset: clears the fill count, sequencer and result valid; ram contents are
//   left as they are and no entry is read before it is written
// ----------------------------------------------------------------------------
// keyed_table_insert_lookup_update
// fixed-capacity key/quantity table with insert, search and signed update
// ----------------------------------------------------------------------------
module keyed_table_insert_lookup_update #(
   parameter int CAPACITY = ktab_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   ktab_req_if.sink          req_bus,
   ktab_rsp_if.source        rsp_bus
);

   ktab_pkg::ctrl_cmd_type  cmd;
   ktab_pkg::dp_status_type dp_status;

   ktab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   ktab_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (dp_status),
      .req_opcode   (req_bus.opcode),
      .req_part_key (req_bus.part_key),
      .req_amount   (req_bus.amount),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_status   (rsp_bus.status),
      .rsp_quantity (rsp_bus.quantity),
      .rsp_slot     (rsp_bus.slot)
   );

endmodule

FILE: src/ktab_checker.sv
// ----------------------------------------------------------------------------
// ktab_checker
// port-level checks on the keyed table, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_table_insert_lookup_update_defines.svh"

module ktab_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic        [ktab_pkg::STATUS_W-1:0]  rsp_status,
   input logic signed [ktab_pkg::DATA_W-1:0]    rsp_quantity,
   input logic        [ktab_pkg::SLOT_W-1:0]    rsp_slot
);

   // a stalled result word stays put
   `KTAB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_quantity) && $stable(rsp_slot), "rsp word changed while stalled")

   // failed commands report zero quantity and slot
   `KTAB_ASSERT(a_fail_zero, clock, reset, rsp_valid && rsp_status != ktab_pkg::ST_OK |-> rsp_quantity == '0 && rsp_slot == '0, "failure result with nonzero payload")

   // only one command is worked on at a time
   `KTAB_ASSERT(a_one_in_flight, clock, reset, req_valid && req_ready |=> !req_ready, "second command taken while busy")

   // nothing is offered right after reset
   `KTAB_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind keyed_table_insert_lookup_update ktab_checker u_ktab_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_status   (rsp_bus.status),
   .rsp_quantity (rsp_bus.quantity),
   .rsp_slot     (rsp_bus.slot)
);
